@@ rtl/srw_pkg.sv @@
// Shared constants, types and register indexes for the selective receive window.
package srw_pkg;

    localparam int unsigned WINDOW_SLOTS = 32;
    localparam int unsigned SEGMENT_SIZE = 1;
    localparam int unsigned SEQ_W        = 32;
    // Wide enough to hold WINDOW_SLOTS itself (all slots received)
    localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS + 1);
    localparam int unsigned CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_SEQ = 1'b1;

    typedef logic [SEQ_W-1:0]        seq_t;
    typedef logic [WINDOW_SLOTS-1:0] slot_map_t;

    typedef struct packed {
        logic [SLOT_W-1:0] first;
        logic              slide;
    } scan_t;

endpackage

@@ rtl/srw_mark.sv @@
// Slot match: compares a sequence number with every slot's expected number.
module srw_mark
(
    input  srw_pkg::seq_t      seq,
    input  srw_pkg::seq_t      base,
    input  srw_pkg::slot_map_t map_in,
    output srw_pkg::slot_map_t map_out,
    output logic               marked
);

    srw_pkg::seq_t      diff;
    srw_pkg::slot_map_t hit;

    assign diff = seq - base;

    // Slot i matches only when the offset is exactly i segments; offsets
    // behind the base have the top bit set and never match.
    always_comb
    begin
        for (int i = 0; i < int'(srw_pkg::WINDOW_SLOTS); i++)
        begin
            hit[i] = (diff == srw_pkg::SEQ_W'(i * int'(srw_pkg::SEGMENT_SIZE)));
        end
    end

    assign map_out = map_in | hit;
    assign marked  = |hit;

endmodule

@@ rtl/srw_scan.sv @@
// First-missing-slot search, acknowledgement number and window slide.
module srw_scan
(
    input  srw_pkg::slot_map_t map_in,
    input  srw_pkg::seq_t      base,
    output srw_pkg::seq_t      ack,
    output srw_pkg::slot_map_t map_out,
    output srw_pkg::scan_t     info
);

    logic [srw_pkg::SLOT_W-1:0] first;

    // Lowest clear bit; WINDOW_SLOTS when every slot is received
    always_comb
    begin
        first = srw_pkg::SLOT_W'(srw_pkg::WINDOW_SLOTS);
        for (int i = int'(srw_pkg::WINDOW_SLOTS) - 1; i >= 0; i--)
        begin
            if (!map_in[i])
            begin
                first = srw_pkg::SLOT_W'(i);
            end
        end
    end

    assign ack = base + srw_pkg::SEQ_W'(srw_pkg::SEQ_W'(first)
                 * srw_pkg::SEQ_W'(srw_pkg::SEGMENT_SIZE));

    assign info.first = first;
    assign info.slide = (first > srw_pkg::SLOT_W'(1));

    // A full window shifts out every bit, leaving the map clear
    assign map_out = info.slide ? srw_pkg::slot_map_t'(map_in >> first) : map_in;

endmodule

@@ rtl/selective_receive_window.sv @@
// Top level of the selective-repeat receive window.
//
// Receiver side of a selective-repeat window of srw_pkg::WINDOW_SLOTS slots.
// Slot i expects window base + i * SEGMENT_SIZE. Each input transaction
// carries the sequence number of one arriving data segment and yields
// exactly one acknowledgement transaction: ack_no is the expected number of
// the first unreceived slot (base + full window when all are received),
// ack_seq is the server sequence register, marked says the segment hit its
// slot, slid says the window moved. The window slides only past a received
// prefix of two or more slots, or the whole window.
// Timing: one transaction per clock sustained while out_ready is high. An
// accepted segment is held in the input register; the match, first-zero
// search and slide are evaluated in a single combinational pass against the
// window state, and the result is written to the output register once that
// register is free or draining. One further segment can be accepted whilst a
// result waits; with both registers full, in_ready stays low until out_ready.
// Back-to-back segments see the state left by the one before.
// Configuration: index CFG_START_SEQ reloads the window base and clears all
// received bits; CFG_SERVER_SEQ sets ack_seq. Write only when idle.
module selective_receive_window
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [srw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srw_pkg::SEQ_W-1:0]     cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srw_pkg::SEQ_W-1:0]     seq_no,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srw_pkg::SEQ_W-1:0]     ack_no,
    output logic [srw_pkg::SEQ_W-1:0]     ack_seq,
    output logic                          marked,
    output logic                          slid
);

    // Input stage
    logic               in_valid_reg;
    srw_pkg::seq_t      seq_reg;

    // Window state
    srw_pkg::seq_t      base_reg;
    srw_pkg::seq_t      base_next;
    srw_pkg::slot_map_t map_reg;
    srw_pkg::slot_map_t map_next;
    srw_pkg::seq_t      server_seq_reg;

    // Result stage
    logic               out_valid_reg;
    srw_pkg::seq_t      ack_no_reg;
    srw_pkg::seq_t      ack_seq_reg;
    logic               marked_reg;
    logic               slid_reg;

    srw_pkg::slot_map_t map_marked;
    logic               hit;
    srw_pkg::seq_t      ack;
    srw_pkg::scan_t     info;
    logic               advance;

    // Evaluate the held segment when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    srw_mark u_mark
    (
        .seq     (seq_reg),
        .base    (base_reg),
        .map_in  (map_reg),
        .map_out (map_marked),
        .marked  (hit)
    );

    srw_scan u_scan
    (
        .map_in  (map_marked),
        .base    (base_reg),
        .ack     (ack),
        .map_out (map_next),
        .info    (info)
    );

    assign base_next = info.slide ? ack : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            base_reg       <= '0;
            map_reg        <= '0;
            server_seq_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration must arrive only while idle; the block does not enforce it, and START_SEQ wins over advance
            if (cfg_we && cfg_index == srw_pkg::CFG_START_SEQ)
            begin
                base_reg <= cfg_data;
                map_reg  <= '0;
            end
            else if (advance)
            begin
                base_reg <= base_next;
                map_reg  <= map_next;
            end

            if (cfg_we && cfg_index == srw_pkg::CFG_SERVER_SEQ)
            begin
                server_seq_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            seq_reg <= seq_no;
        end
        if (advance)
        begin
            ack_no_reg  <= ack;
            ack_seq_reg <= server_seq_reg;
            marked_reg  <= hit;
            slid_reg    <= info.slide;
        end
    end

    assign out_valid = out_valid_reg;
    assign ack_no    = ack_no_reg;
    assign ack_seq   = ack_seq_reg;
    assign marked    = marked_reg;
    assign slid      = slid_reg;

endmodule
